// File: design/tcer_pkg.sv
// Package for the text console renderer: constants, payload structs, controller states
// and the command/status structs shared by controller and datapath. No dependencies.
`timescale 1ns / 1ps
package tcer_pkg;
    localparam int COLUMNS = 80;
    localparam int ROWS = 25;
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW = 11;
    localparam int CW = 8;
    localparam int RW = 7;
    localparam logic [15:0] BLANK_CELL = 16'h0720;
    localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
    localparam logic [AW-1:0] SCROLL_END = AW'(CELLS - COLUMNS);

    typedef struct packed {
        logic          opcode;
        logic [7:0]    byte_in;
        logic [10:0]   cell_address;
    } in_item_t;

    typedef struct packed {
        logic [15:0]   cell_data;
        logic [10:0]   cursor_position;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_EXEC, ST_READ_WAIT, ST_FILL,
        ST_SCROLL_RD, ST_SCROLL_WR, ST_BLANK_ROW, ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic exec;
        logic fill_step;
        logic scroll_rd;
        logic scroll_wr;
        logic blank_step;
        logic clear_step;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic need_fill;
        logic need_scroll;
        logic fill_last;
        logic scroll_last;
        logic blank_last;
        logic clear_last;
    } status_t;
endpackage

// File: design/tcer_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read. No dependencies.
`timescale 1ns / 1ps
module tcer_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/tcer_ctrl.sv
// Controller of the text console renderer: sequences items, fills, scrolls and
// the clearing pass. Depends on tcer_pkg.
`timescale 1ns / 1ps
module tcer_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  tcer_pkg::status_t sts,
    output tcer_pkg::cmd_t    cmd
);
    tcer_pkg::state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcer_pkg::ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign s_ready = (state_reg == tcer_pkg::ST_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tcer_pkg::ST_CLEAR: if (sts.clear_last) state_next = tcer_pkg::ST_IDLE;
            tcer_pkg::ST_IDLE: if (s_valid) state_next = tcer_pkg::ST_EXEC;
            tcer_pkg::ST_EXEC: begin
                if (sts.is_read) state_next = tcer_pkg::ST_READ_WAIT;
                else if (sts.need_fill) state_next = tcer_pkg::ST_FILL;
                else if (sts.need_scroll) state_next = tcer_pkg::ST_SCROLL_RD;
                else state_next = tcer_pkg::ST_OUT;
            end
            tcer_pkg::ST_READ_WAIT: state_next = tcer_pkg::ST_OUT;
            tcer_pkg::ST_FILL: if (sts.fill_last) state_next = tcer_pkg::ST_OUT;
            tcer_pkg::ST_SCROLL_RD: state_next = tcer_pkg::ST_SCROLL_WR;
            tcer_pkg::ST_SCROLL_WR: begin
                if (sts.scroll_last) state_next = tcer_pkg::ST_BLANK_ROW;
                else state_next = tcer_pkg::ST_SCROLL_RD;
            end
            tcer_pkg::ST_BLANK_ROW: if (sts.blank_last) state_next = tcer_pkg::ST_OUT;
            tcer_pkg::ST_OUT: if (!m_valid_reg || m_ready) state_next = tcer_pkg::ST_IDLE;
            default: state_next = tcer_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd = '0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            tcer_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
            tcer_pkg::ST_IDLE: cmd.load_item = s_valid;
            tcer_pkg::ST_EXEC: cmd.exec = 1'b1;
            tcer_pkg::ST_FILL: cmd.fill_step = 1'b1;
            tcer_pkg::ST_SCROLL_RD: cmd.scroll_rd = 1'b1;
            tcer_pkg::ST_SCROLL_WR: cmd.scroll_wr = 1'b1;
            tcer_pkg::ST_BLANK_ROW: cmd.blank_step = 1'b1;
            tcer_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule

// File: design/tcer_dp.sv
// Datapath of the text console renderer: parser registers, cursor arithmetic,
// screen RAM and output register. Depends on tcer_pkg and tcer_ram.
`timescale 1ns / 1ps
module tcer_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  tcer_pkg::in_item_t  s_item,
    output tcer_pkg::out_item_t m_item,
    input  tcer_pkg::cmd_t      cmd,
    output tcer_pkg::status_t   sts
);
    localparam int AW = tcer_pkg::AW;
    localparam int CW = tcer_pkg::CW;
    localparam int RW = tcer_pkg::RW;
    localparam int PH_TEXT = 0;
    localparam int PH_ESC = 1;
    localparam int PH_CSI = 2;
    localparam int PH_PRIV = 3;

    tcer_pkg::in_item_t item_reg, item_next;
    tcer_pkg::out_item_t out_reg, out_next;
    logic [AW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] col_reg, col_next;
    logic [7:0] attr_reg, attr_next;
    logic [1:0] phase_reg, phase_next;
    logic [15:0] fparam_reg, fparam_next, cparam_reg, cparam_next;
    logic [AW-1:0] ptr_reg, ptr_next, end_reg, end_next;
    logic need_scroll_reg, need_scroll_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0] wdata, rdata;

    tcer_ram #(.WIDTH(16), .DEPTH(tcer_pkg::CELLS)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
            col_reg <= '0;
            attr_reg <= 8'h07;
            phase_reg <= '0;
            fparam_reg <= '0;
            cparam_reg <= '0;
            ptr_reg <= '0;
            need_scroll_reg <= 1'b0;
        end else begin
            cursor_reg <= cursor_next;
            col_reg <= col_next;
            attr_reg <= attr_next;
            phase_reg <= phase_next;
            fparam_reg <= fparam_next;
            cparam_reg <= cparam_next;
            ptr_reg <= ptr_next;
            need_scroll_reg <= need_scroll_next;
        end
        item_reg <= item_next;
        out_reg <= out_next;
        end_reg <= end_next;
    end

    assign m_item = out_reg;

    function automatic logic [7:0] sgr(input logic [7:0] a, input logic [15:0] code);
        logic [7:0] r;
        r = a;
        if (code == 16'd0) r = 8'h07;
        else if (code == 16'd1) r = a | 8'h08;
        else if (code == 16'd7) r = {a[3:0], a[7:4]};
        return r;
    endfunction

    logic [7:0] c;
    logic [AW-1:0] row_start;
    logic [AW:0] adv;
    logic [19:0] dec;
    logic [15:0] rowp, colp;
    logic [RW-1:0] rowc;
    logic [CW:0] colc;
    logic [7:0] a1;

    assign c = item_reg.byte_in;
    assign row_start = cursor_reg - AW'(col_reg);

    always_comb begin
        item_next = item_reg;
        out_next = out_reg;
        cursor_next = cursor_reg;
        col_next = col_reg;
        attr_next = attr_reg;
        phase_next = phase_reg;
        fparam_next = fparam_reg;
        cparam_next = cparam_reg;
        ptr_next = ptr_reg;
        end_next = end_reg;
        need_scroll_next = need_scroll_reg;
        sts = '0;
        we = 1'b0;
        waddr = ptr_reg;
        wdata = {attr_reg, 8'h00};
        raddr = item_reg.cell_address;
        adv = '0;
        dec = '0;
        rowp = '0;
        colp = '0;
        rowc = '0;
        colc = '0;
        a1 = '0;

        sts.is_read = item_reg.opcode;
        sts.fill_last = (ptr_reg + 1'b1 == end_reg);
        sts.scroll_last = (ptr_reg == tcer_pkg::SCROLL_END - 1'b1);
        sts.blank_last = (ptr_reg == tcer_pkg::LAST_ADDR);
        sts.clear_last = (ptr_reg == tcer_pkg::LAST_ADDR);

        if (cmd.clear_step) begin
            we = 1'b1;
            wdata = tcer_pkg::BLANK_CELL;
            ptr_next = (ptr_reg == tcer_pkg::LAST_ADDR) ? '0 : ptr_reg + 1'b1;
        end

        if (cmd.load_item) begin
            item_next = s_item;
        end

        if (cmd.exec) begin
            ptr_next = '0;
            end_next = '0;
            need_scroll_next = 1'b0;
            if (!item_reg.opcode) begin
                unique case (int'(phase_reg))
                    PH_ESC: phase_next = (c == 8'h5B) ? 2'(PH_CSI) : 2'(PH_TEXT);
                    PH_PRIV: begin
                        if (!((c >= 8'h30 && c <= 8'h39) || c == 8'h3B)) phase_next = 2'(PH_TEXT);
                    end
                    PH_CSI: begin
                        if (c >= 8'h30 && c <= 8'h39) begin
                            dec = {cparam_reg, 3'b0} + {2'b0, cparam_reg, 1'b0}
                                + 20'(c - 8'h30);
                            cparam_next = (dec > 20'hFFFF) ? 16'hFFFF : dec[15:0];
                        end else if (c == 8'h3B) begin
                            fparam_next = cparam_reg;
                            cparam_next = '0;
                        end else if (c == 8'h3F || c == 8'h5B) begin
                            phase_next = 2'(PH_PRIV);
                        end else begin
                            phase_next = 2'(PH_TEXT);
                            unique case (c)
                                8'h41: begin
                                    if (cursor_reg >= AW'(tcer_pkg::COLUMNS))
                                        cursor_next = cursor_reg - AW'(tcer_pkg::COLUMNS);
                                end
                                8'h42: begin
                                    adv = {1'b0, cursor_reg} + (AW+1)'(tcer_pkg::COLUMNS);
                                end
                                8'h43: begin
                                    adv = {1'b0, cursor_reg} + 1'b1;
                                    col_next = (col_reg == CW'(tcer_pkg::COLUMNS - 1))
                                        ? '0 : col_reg + 1'b1;
                                end
                                8'h44: begin
                                    if (cursor_reg == '0) begin
                                        cursor_next = AW'(tcer_pkg::COLUMNS - 1);
                                        col_next = CW'(tcer_pkg::COLUMNS - 1);
                                    end else begin
                                        cursor_next = cursor_reg - 1'b1;
                                        col_next = (col_reg == '0)
                                            ? CW'(tcer_pkg::COLUMNS - 1) : col_reg - 1'b1;
                                    end
                                end
                                8'h4B: begin
                                    if (cparam_reg == 16'd0) begin
                                        ptr_next = cursor_reg;
                                        end_next = row_start + AW'(tcer_pkg::COLUMNS);
                                    end else if (cparam_reg == 16'd1) begin
                                        ptr_next = row_start;
                                        end_next = cursor_reg + 1'b1;
                                    end else if (cparam_reg == 16'd2 || cparam_reg == 16'd3) begin
                                        ptr_next = row_start;
                                        end_next = row_start + AW'(tcer_pkg::COLUMNS);
                                    end
                                end
                                8'h4A: begin
                                    if (cparam_reg == 16'd0) begin
                                        ptr_next = cursor_reg;
                                        end_next = AW'(tcer_pkg::CELLS);
                                    end else if (cparam_reg == 16'd1) begin
                                        end_next = cursor_reg;
                                    end else if (cparam_reg == 16'd2 || cparam_reg == 16'd3) begin
                                        end_next = AW'(tcer_pkg::CELLS);
                                    end
                                end
                                8'h6D: begin
                                    a1 = (fparam_reg != 16'd0) ? sgr(attr_reg, fparam_reg)
                                                               : attr_reg;
                                    attr_next = sgr(a1, cparam_reg);
                                end
                                8'h48: begin
                                    if (fparam_reg == 16'd0) begin
                                        rowp = cparam_reg;
                                        colp = 16'd1;
                                    end else begin
                                        rowp = fparam_reg;
                                        colp = cparam_reg;
                                    end
                                    if (rowp == 16'd0) rowp = 16'd1;
                                    if (colp == 16'd0) colp = 16'd1;
                                    if (rowp > 16'(tcer_pkg::ROWS)) rowp = 16'(tcer_pkg::ROWS);
                                    if (colp > 16'(tcer_pkg::COLUMNS))
                                        colp = 16'(tcer_pkg::COLUMNS);
                                    rowc = RW'(rowp - 16'd1);
                                    colc = (CW+1)'(colp - 16'd1);
                                    cursor_next = AW'(rowc * AW'(tcer_pkg::COLUMNS))
                                        + AW'(colc);
                                    col_next = CW'(colc);
                                end
                                default: ;
                            endcase
                        end
                    end
                    default: begin
                        unique case (c)
                            8'd8: begin
                                if (cursor_reg != '0) begin
                                    cursor_next = cursor_reg - 1'b1;
                                    col_next = (col_reg == '0)
                                        ? CW'(tcer_pkg::COLUMNS - 1) : col_reg - 1'b1;
                                    we = 1'b1;
                                    waddr = cursor_reg - 1'b1;
                                    wdata = {attr_reg, 8'h20};
                                end
                            end
                            8'd10: begin
                                adv = {1'b0, row_start} + (AW+1)'(tcer_pkg::COLUMNS);
                                col_next = '0;
                            end
                            8'd13: begin
                                cursor_next = row_start;
                                col_next = '0;
                            end
                            8'd27: begin
                                phase_next = 2'(PH_ESC);
                                fparam_next = '0;
                                cparam_next = '0;
                            end
                            default: begin
                                we = 1'b1;
                                waddr = cursor_reg;
                                wdata = {attr_reg, (c == 8'd9) ? 8'h20 : c};
                                adv = {1'b0, cursor_reg} + 1'b1;
                                col_next = (col_reg == CW'(tcer_pkg::COLUMNS - 1))
                                    ? '0 : col_reg + 1'b1;
                            end
                        endcase
                    end
                endcase
                if (adv != '0) begin
                    if (adv >= (AW+1)'(tcer_pkg::CELLS)) begin
                        cursor_next = AW'(adv - (AW+1)'(tcer_pkg::COLUMNS));
                        need_scroll_next = 1'b1;
                    end else begin
                        cursor_next = AW'(adv);
                    end
                end
            end
        end

        if (cmd.fill_step) begin
            we = 1'b1;
            ptr_next = ptr_reg + 1'b1;
        end

        if (cmd.scroll_rd) begin
            raddr = ptr_reg + AW'(tcer_pkg::COLUMNS);
        end

        if (cmd.scroll_wr) begin
            we = 1'b1;
            wdata = rdata;
            ptr_next = ptr_reg + 1'b1;
        end

        if (cmd.blank_step) begin
            we = 1'b1;
            wdata = tcer_pkg::BLANK_CELL;
            ptr_next = ptr_reg + 1'b1;
        end

        if (cmd.out_load) begin
            out_next.cursor_position = cursor_reg;
            out_next.cell_data = '0;
            if (item_reg.opcode && item_reg.cell_address < AW'(tcer_pkg::CELLS))
                out_next.cell_data = rdata;
        end

        sts.need_fill = (end_next != ptr_next);
        sts.need_scroll = need_scroll_next;
    end
endmodule

// File: design/text_console_escape_renderer_unit.sv
// Top level of the text console renderer: joins controller and datapath.
// Depends on tcer_pkg, tcer_ctrl and tcer_dp.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_item  (tcer_pkg::in_item_t)
//  m_      | out       | m_valid / m_ready  | m_item  (tcer_pkg::out_item_t)
//
// One item at a time: after accept a plain byte passes through EXEC and OUT, a read
// through EXEC, READ_WAIT and OUT; s_ready returns as the result loads.
// Erase adds a FILL step per cell filled (up to 2000); a scroll reads, then writes,
// each moved cell and blanks each bottom-row cell, all through the one screen RAM.
// After reset a clearing pass blanks all 2000 cells; s_ready stays low meanwhile.
// A result held by m_ready low stalls the next item.
`timescale 1ns / 1ps
module text_console_escape_renderer_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tcer_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output tcer_pkg::out_item_t m_item
);
    tcer_pkg::cmd_t cmd;
    tcer_pkg::status_t sts;

    tcer_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    tcer_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_item(s_item), .m_item(m_item),
        .cmd(cmd), .sts(sts)
    );
endmodule
